// ----- design/bmhq_pkg.sv -----
// Shared types and constants for the binary max-heap queue.
// Holds opcodes, result status codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package bmhq_pkg;

	// Default number of heap slots
	localparam int unsigned CAPACITY_DEF = 64;

	// Fixed payload widths
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned MOVES_W = 4;
	localparam int unsigned SIZE_W  = 7;
	localparam int unsigned STAT_W  = 2;

	// Packed stream widths (output tdata padded to whole bytes)
	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_USED_W = VAL_W + MOVES_W + SIZE_W + VAL_W;
	localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} bmhq_op_t;

	typedef enum logic [STAT_W-1:0] {
		RES_INSERTED = 2'd0,
		RES_REMOVED  = 2'd1,
		RES_EMPTY    = 2'd2,
		RES_FULL     = 2'd3
	} bmhq_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_LAST_RD,
		ST_LAST_LD,
		ST_DN_RD,
		ST_DN_CMP,
		ST_FIN
	} bmhq_state_t;

	// Which addresses the heap RAM read ports look at
	typedef enum logic [1:0] {
		RD_PARENT,
		RD_LAST,
		RD_CHILD
	} bmhq_rd_t;

	// What the heap RAM write port stores at the hole position
	typedef enum logic [1:0] {
		WR_NONE,
		WR_PLACE,
		WR_UP,
		WR_DOWN
	} bmhq_wr_t;

	typedef struct packed {
		logic     accept;
		bmhq_rd_t rd_sel;
		logic     load_last;
		bmhq_wr_t wr_kind;
		logic     fin;
	} bmhq_cmd_t;

	typedef struct packed {
		logic ins_op;
		logic full;
		logic empty;
		logic one_left;
		logic at_root;
		logic leaf;
		logic go_up;
		logic go_down;
		logic out_free;
	} bmhq_stat_t;

endpackage

`default_nettype wire

// ----- design/bmhq_ram.sv -----
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module bmhq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then register both reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

// ----- design/bmhq_ctrl.sv -----
// Controller state machine for the heap queue: sequences sift-up and
// sift-down levels. Depends on bmhq_pkg.
`default_nettype none

module bmhq_ctrl
	import bmhq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire bmhq_stat_t stat,
	output bmhq_cmd_t       cmd
);

	bmhq_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		cmd.accept    = 1'b0;
		cmd.rd_sel    = RD_PARENT;
		cmd.load_last = 1'b0;
		cmd.wr_kind   = WR_NONE;
		cmd.fin       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (stat.ins_op) begin
						state_d = stat.full ? ST_FIN : ST_UP_RD;
					end else if (stat.empty || stat.one_left) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_LAST_RD;
					end
				end
			end
			ST_UP_RD: begin
				cmd.rd_sel = RD_PARENT;
				if (stat.at_root) begin
					cmd.wr_kind = WR_PLACE;
					state_d     = ST_FIN;
				end else begin
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				if (stat.go_up) begin
					cmd.wr_kind = WR_UP;
					state_d     = ST_UP_RD;
				end else begin
					cmd.wr_kind = WR_PLACE;
					state_d     = ST_FIN;
				end
			end
			ST_LAST_RD: begin
				cmd.rd_sel = RD_LAST;
				state_d    = ST_LAST_LD;
			end
			ST_LAST_LD: begin
				cmd.load_last = 1'b1;
				state_d       = ST_DN_RD;
			end
			ST_DN_RD: begin
				cmd.rd_sel = RD_CHILD;
				if (stat.leaf) begin
					cmd.wr_kind = WR_PLACE;
					state_d     = ST_FIN;
				end else begin
					state_d = ST_DN_CMP;
				end
			end
			ST_DN_CMP: begin
				if (stat.go_down) begin
					cmd.wr_kind = WR_DOWN;
					state_d     = ST_DN_RD;
				end else begin
					cmd.wr_kind = WR_PLACE;
					state_d     = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/bmhq_dpath.sv -----
// Datapath for the heap queue: heap RAM, element count, moving value,
// hole position, root mirror and the result register.
// Depends on bmhq_pkg and bmhq_ram.
`default_nettype none

module bmhq_dpath
	import bmhq_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [OUT_DATA_W-1:0] m_tdata,
	output logic      [STAT_W-1:0]     m_tuser,
	input  wire bmhq_cmd_t             cmd,
	output bmhq_stat_t                 stat
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = AW + 2;

	logic        [CW-1:0]      count_q;
	logic        [AW-1:0]      pos_q;
	logic signed [VAL_W-1:0]   val_q;
	logic signed [VAL_W-1:0]   root_q;
	logic signed [VAL_W-1:0]   removed_q;
	logic        [MOVES_W-1:0] moves_q;
	bmhq_res_t                 res_q;

	logic                      out_valid_q;
	logic        [STAT_W-1:0]  out_user_q;
	logic        [OUT_DATA_W-1:0] out_data_q;

	logic        [AW-1:0]      parent;
	logic        [IW-1:0]      left_ix;
	logic        [IW-1:0]      right_ix;
	logic        [IW-1:0]      count_ix;
	logic                      right_ok;
	logic signed [VAL_W-1:0]   rd_a;
	logic signed [VAL_W-1:0]   rd_b;
	logic signed [VAL_W-1:0]   best_val;
	logic        [AW-1:0]      best_pos;
	logic        [AW-1:0]      raddr_a;
	logic        [AW-1:0]      raddr_b;
	logic                      we;
	logic signed [VAL_W-1:0]   wdata;
	logic        [SIZE_W-1:0]  count_ext;
	logic signed [VAL_W-1:0]   top_val;

	// Tree neighbors of the hole position
	assign parent   = (pos_q - AW'(1)) >> 1;
	assign left_ix  = IW'({pos_q, 1'b1});
	assign right_ix = left_ix + IW'(1);
	assign count_ix = IW'(count_q);
	assign right_ok = right_ix < count_ix;
	assign best_val = (right_ok && (rd_b > rd_a)) ? rd_b : rd_a;
	assign best_pos = (right_ok && (rd_b > rd_a)) ? right_ix[AW-1:0] : left_ix[AW-1:0];

	// Read address select
	always_comb begin
		raddr_a = parent;
		raddr_b = right_ix[AW-1:0];
		unique case (cmd.rd_sel)
			RD_PARENT: raddr_a = parent;
			RD_LAST:   raddr_a = count_q[AW-1:0];
			RD_CHILD:  raddr_a = left_ix[AW-1:0];
			default:   raddr_a = parent;
		endcase
	end

	// Write data select: the moving value, or a neighbor shifted into the hole
	always_comb begin
		we    = 1'b1;
		wdata = val_q;
		unique case (cmd.wr_kind)
			WR_NONE:  we = 1'b0;
			WR_PLACE: wdata = val_q;
			WR_UP:    wdata = rd_a;
			WR_DOWN:  wdata = best_val;
			default:  we = 1'b0;
		endcase
	end

	bmhq_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (pos_q),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Status toward the controller
	assign stat.ins_op   = (bmhq_op_t'(s_tuser) == OP_INSERT);
	assign stat.full     = (count_q == CW'(CAPACITY));
	assign stat.empty    = (count_q == '0);
	assign stat.one_left = (count_q == CW'(1));
	assign stat.at_root  = (pos_q == '0);
	assign stat.leaf     = (left_ix >= count_ix);
	assign stat.go_up    = (val_q > rd_a);
	assign stat.go_down  = (best_val > val_q);
	assign stat.out_free = !out_valid_q || m_tready;

	// Control registers: element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.accept) begin
			if (stat.ins_op && !stat.full) begin
				count_q <= count_q + CW'(1);
			end else if (!stat.ins_op && !stat.empty) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Working registers of the current item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q     <= s_tdata;
			pos_q     <= count_q[AW-1:0];
			moves_q   <= '0;
			removed_q <= '0;
			if (stat.ins_op) begin
				res_q <= stat.full ? RES_FULL : RES_INSERTED;
			end else if (stat.empty) begin
				res_q <= RES_EMPTY;
			end else begin
				res_q     <= RES_REMOVED;
				removed_q <= root_q;
			end
		end else if (cmd.load_last) begin
			val_q <= rd_a;
			pos_q <= '0;
		end else if (cmd.wr_kind == WR_UP) begin
			pos_q   <= parent;
			moves_q <= (moves_q == '1) ? moves_q : moves_q + MOVES_W'(1);
		end else if (cmd.wr_kind == WR_DOWN) begin
			pos_q   <= best_pos;
			moves_q <= (moves_q == '1) ? moves_q : moves_q + MOVES_W'(1);
		end
		// Mirror the root slot
		if (we && (pos_q == '0)) begin
			root_q <= wdata;
		end
	end

	assign count_ext = SIZE_W'(count_q);
	assign top_val   = (count_q != '0) ? root_q : '0;

	// Output register: load on finish, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_user_q <= res_q;
			out_data_q <= OUT_DATA_W'({top_val, count_ext[SIZE_W-1:0], moves_q, removed_q});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_user_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- design/binary_max_heap_queue.sv -----
// Bounded max-priority queue kept as an implicit binary heap in one RAM.
// Channels: input stream s_* carries an operation (tuser: 0 insert, 1 remove)
// and a signed 32-bit value (tdata); output stream m_* returns one item per
// input item: status in tuser, removed value, swap count, size and top in tdata.
// From accept, an insert sifts up through ST_UP_RD and ST_UP_CMP per level,
// placing the value when it loses a compare or reaches the root; a remove
// reads the last element (ST_LAST_RD, ST_LAST_LD), then sifts down through
// ST_DN_RD and ST_DN_CMP per level until it loses a compare or ends on a leaf.
// Each level is one RAM read state and one compare/write state on the shared
// heap RAM port pair. A full insert, an empty remove or the remove of the last
// element goes straight from accept to ST_FIN without sifting.
// One item is worked on at a time; the next is accepted after the result is
// handed to the output register. A result waiting on a stalled receiver does
// not block the next item's sift; only its own finish waits for the register.
// Reset clears the controller state, the element count and the output valid;
// RAM contents need none. Depends on bmhq_pkg, bmhq_ctrl, bmhq_dpath and bmhq_ram.
`default_nettype none

module binary_max_heap_queue
	import bmhq_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // [31:0] value
	input  wire logic                  s_tuser,  // [0] opcode
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [OUT_DATA_W-1:0] m_tdata,  // removed_value, moves, size_after, top_value
	output logic      [STAT_W-1:0]     m_tuser   // [1:0] status
);

	bmhq_cmd_t  cmd;
	bmhq_stat_t stat;

	bmhq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bmhq_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

`default_nettype wire
